/* rtl/core/hspd_pkg.sv */
`timescale 1ns / 1ps

package hspd_pkg;

	localparam int unsigned SAMPLE_W  = 12;
	localparam int unsigned COUNT_W   = 16;
	localparam int unsigned RATIO_W   = 8;
	localparam int unsigned HITS_W    = 8;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DAT_W = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_SAMPLES = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ON_RATIO      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_RATIO     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_COUNT = 4'd3;

	// reset values of the registers
	localparam logic [COUNT_W-1:0] CALIB_SAMPLES_RST = 16'd400;
	localparam logic [RATIO_W-1:0] ON_RATIO_RST      = 8'd18;
	localparam logic [RATIO_W-1:0] OFF_RATIO_RST     = 8'd12;
	localparam logic [HITS_W-1:0]  CONFIRM_COUNT_RST = 8'd5;

	localparam logic [HITS_W-1:0] HITS_MAX = 8'hFF;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                armed;
	} in_beat_t;

	typedef struct packed {
		logic                fire;
		logic                calibrating;
		logic [SAMPLE_W-1:0] resting_level;
		logic [SAMPLE_W-1:0] max_deviation;
	} out_beat_t;

endpackage

/* rtl/core/hall_sensor_press_detector_core.sv */
`timescale 1ns / 1ps
// Path: each beat goes from the input register beat_s1 into the result register out_q;
// while a result is held by out_ready low, the beat in the input register waits.
// One beat per cycle unless stalled; with both stages full, in_ready follows out_ready.
// Reset (arst_n low, asynchronous): levels, counters and handshake flags clear,
// configuration registers return to 400 / 18 / 12 / 5.

module hall_sensor_press_detector_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  hspd_pkg::in_beat_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output hspd_pkg::out_beat_t               out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hspd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hspd_pkg::CFG_DAT_W-1:0]    cfg_data
);

	// configuration
	logic [hspd_pkg::COUNT_W-1:0] calib_samples_q;
	logic [hspd_pkg::RATIO_W-1:0] on_ratio_q;
	logic [hspd_pkg::RATIO_W-1:0] off_ratio_q;
	logic [hspd_pkg::HITS_W-1:0]  confirm_q;

	// detector state
	logic [hspd_pkg::SAMPLE_W-1:0] rest_q;
	logic [hspd_pkg::SAMPLE_W-1:0] peak_q;
	logic [hspd_pkg::COUNT_W-1:0]  count_q;
	logic [hspd_pkg::HITS_W-1:0]   hits_q;

	// input register stage
	logic               valid_s1;
	hspd_pkg::in_beat_t beat_s1;

	// result register
	logic                out_valid_q;
	hspd_pkg::out_beat_t out_q;

	logic advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_samples_q <= hspd_pkg::CALIB_SAMPLES_RST;
			on_ratio_q      <= hspd_pkg::ON_RATIO_RST;
			off_ratio_q     <= hspd_pkg::OFF_RATIO_RST;
			confirm_q       <= hspd_pkg::CONFIRM_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hspd_pkg::REG_CALIB_SAMPLES: begin
					calib_samples_q <= cfg_data;
				end
				hspd_pkg::REG_ON_RATIO: begin
					on_ratio_q <= cfg_data[hspd_pkg::RATIO_W-1:0];
				end
				hspd_pkg::REG_OFF_RATIO: begin
					off_ratio_q <= cfg_data[hspd_pkg::RATIO_W-1:0];
				end
				hspd_pkg::REG_CONFIRM_COUNT: begin
					confirm_q <= cfg_data[hspd_pkg::HITS_W-1:0];
				end
				default: begin
					// unknown index: write dropped
				end
			endcase
		end
	end

	// ---- per-sample update, all from beat_s1 and the state registers ----
	logic                           calibrating;
	logic [hspd_pkg::SAMPLE_W+2:0]  blend;      // 7*rest + sample, max 32760
	logic [hspd_pkg::SAMPLE_W-1:0]  rest_cal;
	logic [hspd_pkg::SAMPLE_W-1:0]  dev_cal;
	logic [hspd_pkg::SAMPLE_W-1:0]  peak_base;
	logic [hspd_pkg::SAMPLE_W-1:0]  peak_cal;
	logic [hspd_pkg::SAMPLE_W-1:0]  dev_run;
	logic [hspd_pkg::SAMPLE_W-1:0]  peak_run;
	logic [hspd_pkg::SAMPLE_W+3:0]  dev_x10;    // max 40950
	logic [hspd_pkg::SAMPLE_W+7:0]  on_thr;
	logic [hspd_pkg::SAMPLE_W+7:0]  off_thr;
	logic                           press;
	logic                           release_hit;
	logic                           fire;
	logic [hspd_pkg::SAMPLE_W-1:0]  rest_nx;
	logic [hspd_pkg::SAMPLE_W-1:0]  peak_nx;
	logic [hspd_pkg::HITS_W-1:0]    hits_nx;

	assign calibrating = count_q < calib_samples_q;

	// resting level: load on zero, else 7/8 old + 1/8 new, floored
	assign blend    = ({rest_q, 3'b000} - {3'b000, rest_q}) + {3'b000, beat_s1.sample};
	assign rest_cal = (rest_q == '0) ? beat_s1.sample : blend[hspd_pkg::SAMPLE_W+2:3];
	assign dev_cal  = (beat_s1.sample > rest_cal) ? beat_s1.sample - rest_cal
	                                              : rest_cal - beat_s1.sample;
	assign peak_base = (rest_q == '0) ? '0 : peak_q;

	always_comb begin
		peak_cal = (dev_cal > peak_base) ? dev_cal : peak_base;
		if (peak_cal == '0) begin
			peak_cal = hspd_pkg::SAMPLE_W'(1);
		end
	end

	// detection compares: 10*dev against ratio*peak, peak floored at 1
	assign dev_run  = (beat_s1.sample > rest_q) ? beat_s1.sample - rest_q
	                                            : rest_q - beat_s1.sample;
	assign peak_run = (peak_q == '0) ? hspd_pkg::SAMPLE_W'(1) : peak_q;
	assign dev_x10  = {1'b0, dev_run, 3'b000} + {3'b000, dev_run, 1'b0};
	assign on_thr   = on_ratio_q * peak_run;
	assign off_thr  = off_ratio_q * peak_run;
	assign press       = {4'b0000, dev_x10} > on_thr;
	assign release_hit = {4'b0000, dev_x10} < off_thr;

	always_comb begin
		rest_nx = rest_q;
		peak_nx = peak_q;
		hits_nx = hits_q;
		fire    = 1'b0;
		if (calibrating) begin
			rest_nx = rest_cal;
			peak_nx = peak_cal;
		end else if (beat_s1.armed) begin
			if (press) begin
				// saturated counter never fires
				fire = (hits_q == confirm_q) && (hits_q != hspd_pkg::HITS_MAX);
				if (hits_q != hspd_pkg::HITS_MAX) begin
					hits_nx = hits_q + 1'b1;
				end
			end else if (release_hit) begin
				hits_nx = '0;
			end
		end
	end

	// input register: take a beat whenever the stage is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= in_data;
		end
	end

	// state commits as the beat moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q  <= '0;
			peak_q  <= '0;
			count_q <= '0;
			hits_q  <= '0;
		end else if (advance) begin
			rest_q <= rest_nx;
			peak_q <= peak_nx;
			hits_q <= hits_nx;
			if (calibrating) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.fire          <= fire;
			out_q.calibrating   <= calibrating;
			out_q.resting_level <= rest_nx;
			out_q.max_deviation <= peak_nx;
		end
	end

endmodule

/* rtl/core/hspd_checker.sv */
`timescale 1ns / 1ps

module hspd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input hspd_pkg::out_beat_t out_data
);

	// fire is only raised once calibration is over
	a_fire_after_calib: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.fire |-> !out_data.calibrating)
		else $error("fire during calibration");

	// peak is floored at 1 by every calibration beat
	a_peak_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.calibrating |-> out_data.max_deviation != '0)
		else $error("zero peak after calibration beat");

	// an empty result register never back-pressures the input
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while stalled");

endmodule

bind hall_sensor_press_detector_core hspd_checker u_hspd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
